// ----- hw/rtl/ccs_pkg.sv -----
// Package for the CSV cell splitter: store geometry, character codes and
// controller state type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ccs_pkg;

	localparam int CELL_MAX = 64;
	localparam int CELL_AW  = $clog2(CELL_MAX);
	localparam int CELL_LW  = $clog2(CELL_MAX + 1);

	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT,
		ST_FLUSH
	} state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ccs_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ccs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- hw/rtl/csv_cell_splitter_top.sv -----
// CSV cell splitter top level: byte intake, cell store and decoding read-out.
// Depends on ccs_pkg and ccs_ram.
`timescale 1ns / 1ps
`default_nettype none

// A byte is taken when start is high and busy is low. A byte kept in the cell
// leaves busy low, so such bytes may come every cycle. A comma at even quote
// parity or a newline closes the cell: busy then rises and stays high while
// the stored bytes between the stripped wrapping quotes are read out, because
// the single read port of the cell store delivers one byte per cycle. Results
// appear one per cycle or with gaps where doubled quotes collapse, each marked
// by strobe for one cycle; the last one of a cell shows in the cycle in which
// busy falls. Results cannot be held off.
module csv_cell_splitter_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [7:0] in_byte,
	output logic            strobe,
	output logic      [7:0] data_byte,
	output logic            empty_cell,
	output logic            last_of_cell,
	output logic            end_of_row,
	output logic            quote_error,
	output logic            truncated
);

	ccs_pkg::state_t state_q, state_d;

	logic [ccs_pkg::CELL_LW-1:0] cell_len_q;
	logic                        parity_q;
	logic                        overflow_q;
	logic                        first_quote_q;
	logic                        last_quote_q;

	logic [ccs_pkg::CELL_LW-1:0] rd_addr_q;
	logic [ccs_pkg::CELL_LW-1:0] end_q;
	logic [ccs_pkg::CELL_LW-1:0] rd_next;
	logic                        rd_valid_s1;
	logic [7:0]                  rdata;

	logic       pend_valid_q;
	logic [7:0] pend_byte_q;
	logic       prev_quote_q;

	logic       strobe_q;
	logic [7:0] data_q;
	logic       empty_q;
	logic       last_q;
	logic       eor_q;
	logic       qerr_q;
	logic       trunc_q;

	logic                        accept;
	logic                        is_newline;
	logic                        is_quote;
	logic                        closes;
	logic                        store_we;
	logic                        wrapped;
	logic [ccs_pkg::CELL_LW-1:0] span_lo;
	logic [ccs_pkg::CELL_LW-1:0] span_hi;
	logic                        span_any;
	logic                        issue_rd;
	logic                        rd_drop;

	assign accept     = start && !busy;
	assign is_newline = (in_byte == ccs_pkg::CH_NEWLINE);
	assign is_quote   = (in_byte == ccs_pkg::CH_QUOTE);
	assign closes     = is_newline || ((in_byte == ccs_pkg::CH_COMMA) && !parity_q);
	assign store_we   = accept && !closes
		&& (cell_len_q < ccs_pkg::CELL_LW'(ccs_pkg::CELL_MAX));

	assign wrapped = (cell_len_q != '0) && first_quote_q && last_quote_q;

	always_comb begin
		span_lo = '0;
		span_hi = cell_len_q;
		if (wrapped) begin
			if (cell_len_q >= ccs_pkg::CELL_LW'(2)) begin
				span_lo = ccs_pkg::CELL_LW'(1);
				span_hi = cell_len_q - ccs_pkg::CELL_LW'(1);
			end else begin
				span_hi = '0;
			end
		end
	end

	assign span_any = (span_lo < span_hi);
	assign rd_next  = rd_addr_q + ccs_pkg::CELL_LW'(1);
	assign rd_drop  = (rdata == ccs_pkg::CH_QUOTE) && prev_quote_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ccs_pkg::ST_IDLE: begin
				if (accept && closes) begin
					state_d = span_any ? ccs_pkg::ST_SCAN : ccs_pkg::ST_FLUSH;
				end
			end
			ccs_pkg::ST_SCAN: begin
				if (rd_next == end_q) begin
					state_d = ccs_pkg::ST_WAIT;
				end
			end
			ccs_pkg::ST_WAIT:  state_d = ccs_pkg::ST_FLUSH;
			ccs_pkg::ST_FLUSH: state_d = ccs_pkg::ST_IDLE;
			default:           state_d = ccs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy     = 1'b1;
		issue_rd = 1'b0;
		unique case (state_q)
			ccs_pkg::ST_IDLE: busy = 1'b0;
			ccs_pkg::ST_SCAN: issue_rd = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ccs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Intake of the open cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_len_q    <= '0;
			parity_q      <= 1'b0;
			overflow_q    <= 1'b0;
			first_quote_q <= 1'b0;
			last_quote_q  <= 1'b0;
		end else if (accept) begin
			if (closes) begin
				cell_len_q    <= '0;
				parity_q      <= 1'b0;
				overflow_q    <= 1'b0;
				first_quote_q <= 1'b0;
				last_quote_q  <= 1'b0;
			end else begin
				if (is_quote) begin
					parity_q <= !parity_q;
				end
				if (store_we) begin
					cell_len_q   <= cell_len_q + ccs_pkg::CELL_LW'(1);
					last_quote_q <= is_quote;
					if (cell_len_q == '0) begin
						first_quote_q <= is_quote;
					end
				end else begin
					overflow_q <= 1'b1;
				end
			end
		end
	end

	ccs_ram #(
		.WIDTH(8),
		.DEPTH(ccs_pkg::CELL_MAX)
	) u_store (
		.clk  (clk),
		.we   (store_we),
		.waddr(cell_len_q[ccs_pkg::CELL_AW-1:0]),
		.wdata(in_byte),
		.raddr(rd_addr_q[ccs_pkg::CELL_AW-1:0]),
		.rdata(rdata)
	);

	// Read-out: latch span and flags at close, advance read address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= issue_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && closes) begin
			rd_addr_q <= span_lo;
			end_q     <= span_hi;
			eor_q     <= is_newline;
			qerr_q    <= is_newline && parity_q;
			trunc_q   <= overflow_q;
		end else if (issue_rd) begin
			rd_addr_q <= rd_next;
		end
	end

	// Decode: collapse doubled quotes, hold one byte back to mark the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			prev_quote_q <= 1'b0;
			strobe_q     <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (accept && closes) begin
				pend_valid_q <= 1'b0;
				prev_quote_q <= 1'b0;
			end else if (rd_valid_s1) begin
				if (rd_drop) begin
					prev_quote_q <= 1'b0;
				end else begin
					prev_quote_q <= (rdata == ccs_pkg::CH_QUOTE);
					pend_valid_q <= 1'b1;
					strobe_q     <= pend_valid_q;
				end
			end else if (state_q == ccs_pkg::ST_FLUSH) begin
				strobe_q     <= 1'b1;
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_valid_s1 && !rd_drop) begin
			pend_byte_q <= rdata;
			data_q      <= pend_byte_q;
			empty_q     <= 1'b0;
			last_q      <= 1'b0;
		end else if (state_q == ccs_pkg::ST_FLUSH) begin
			data_q  <= pend_valid_q ? pend_byte_q : 8'h00;
			empty_q <= !pend_valid_q;
			last_q  <= 1'b1;
		end
	end

	assign strobe       = strobe_q;
	assign data_byte    = data_q;
	assign empty_cell   = empty_q;
	assign last_of_cell = last_q;
	assign end_of_row   = eor_q;
	assign quote_error  = qerr_q;
	assign truncated    = trunc_q;

endmodule

`default_nettype wire

// ----- hw/rtl/ccs_checker.sv -----
// Port-level checker for the CSV cell splitter, bound to the top level.
// Depends on ccs_pkg and csv_cell_splitter_top.
`timescale 1ns / 1ps
`default_nettype none

module ccs_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic [7:0] in_byte,
	input wire logic       strobe,
	input wire logic [7:0] data_byte,
	input wire logic       empty_cell,
	input wire logic       last_of_cell
);

	a_newline_closes: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (in_byte == ccs_pkg::CH_NEWLINE) |=> busy)
		else $error("newline request did not close a cell");

	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_of_cell |-> busy)
		else $error("non-final result outside a read-out");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_of_cell |-> !busy)
		else $error("final result while still busy");

	a_busy_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe && last_of_cell)
		else $error("read-out ended without a final result");

	a_empty_marker: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && empty_cell |-> last_of_cell && (data_byte == 8'h00))
		else $error("malformed empty marker");

endmodule

bind csv_cell_splitter_top ccs_checker u_ccs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.in_byte     (in_byte),
	.strobe      (strobe),
	.data_byte   (data_byte),
	.empty_cell  (empty_cell),
	.last_of_cell(last_of_cell)
);

`default_nettype wire
